### rtl/lru_block_buffer_cache_defines.svh
// assertion macros shared by the checker of the buffer cache
// no dependencies
`ifndef LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
// implication checked on every clock, held off during reset
`define LBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication held off during reset
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

### rtl/lbc_pkg.sv
// types and codes of the buffer cache
// no dependencies
`timescale 1ns / 1ps
package lbc_pkg;
    localparam int BLK_W = 24;
    localparam int IDX_W = 4;

    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_DWRITE  = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    localparam logic [1:0] DISK_NONE  = 2'd0;
    localparam logic [1:0] DISK_READ  = 2'd1;
    localparam logic [1:0] DISK_WRITE = 2'd2;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [BLK_W-1:0] block_number;
        logic [IDX_W-1:0] buffer_index;
    } lbc_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] buffer_index_out;
        logic             hit;
        logic             status;
        logic [1:0]       disk_op;
        logic [BLK_W-1:0] disk_block;
        logic [IDX_W-1:0] disk_buffer;
        logic             last;
    } lbc_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic scan_clr;  // reset scan pointer
        logic scan_step; // advance scan pointer
        logic lst_clr;   // reset list pointer
        logic lst_step;  // advance list pointer (compacting)
        logic commit;    // apply the operation result
        logic flush_wb;  // clean the scanned buffer
        logic append;    // put target at list tail
    } lbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic lst_done;
        logic hit;
        logic scan_dirty;
        logic scan_last;  // no dirty buffer other than the scanned one
    } lbc_sts_t;
endpackage

### rtl/lbc_datapath.sv
// state arrays, tag search, free list and result formation
// depends on lbc_pkg
`timescale 1ns / 1ps
module lbc_datapath
    import lbc_pkg::*;
#(
    parameter int NUM_BUFFERS = 16,
    parameter int BLOCK_BITS  = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  lbc_in_t  in_beat,
    input  lbc_cmd_t cmd,
    output lbc_sts_t sts,
    output logic     miss_empty,
    output logic     victim_dirty,
    output logic     need_read,
    output logic     idx_ok,
    output logic     any_dirty_reg_o,
    output logic [IDX_W-1:0] grant_idx,
    output logic [BLK_W-1:0] victim_tag,
    output logic [BLK_W-1:0] buf_tag,
    output logic [BLK_W-1:0] scan_tag,
    output logic [IDX_W-1:0] scan_idx
);
    localparam int BW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);

    logic [BLOCK_BITS-1:0] tag_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] mapped_reg, valid_reg, dirty_reg, onlist_reg;
    logic [BW-1:0] order_reg [NUM_BUFFERS];
    logic [CW-1:0] count_reg;

    logic [2:0]            op_reg;
    logic [BLOCK_BITS-1:0] blk_reg;
    logic [IDX_W-1:0]      bi_reg;
    logic [CW-1:0]         scan_reg;
    logic [CW-1:0]         lp_reg;
    logic                  found_reg;
    logic [BW-1:0]         hidx_reg;
    logic [BW-1:0]         victim_reg;
    logic                  removing_reg;
    logic [BW-1:0]         tgt;
    logic [BW-1:0]         sc;
    logic [NUM_BUFFERS-1:0] sc_bit;

    assign sc = scan_reg[BW-1:0];
    assign sc_bit = NUM_BUFFERS'(1) << sc;
    assign idx_ok = ({{(32-IDX_W){1'b0}}, bi_reg} < NUM_BUFFERS);
    // victim is the list head seen when the beat was taken
    assign tgt = (op_reg == OP_GET || op_reg == OP_READ)
        ? (found_reg ? hidx_reg : victim_reg) : bi_reg[BW-1:0];

    assign sts.scan_done  = (scan_reg == CW'(NUM_BUFFERS));
    assign sts.lst_done   = (lp_reg >= count_reg);
    assign sts.hit        = found_reg;
    assign sts.scan_dirty = !sts.scan_done && dirty_reg[sc];
    assign sts.scan_last  = !(|(dirty_reg & ~sc_bit));

    assign miss_empty   = !found_reg && (count_reg == '0);
    assign victim_dirty = dirty_reg[tgt];
    assign need_read    = found_reg ? (!valid_reg[tgt] && !dirty_reg[tgt]) : 1'b1;
    assign any_dirty_reg_o = |dirty_reg;
    assign grant_idx  = IDX_W'(tgt);
    assign victim_tag = BLK_W'(tag_reg[tgt]);
    assign buf_tag    = found_reg ? BLK_W'(tag_reg[tgt]) : BLK_W'(blk_reg);
    assign scan_tag   = BLK_W'(tag_reg[sc]);
    assign scan_idx   = IDX_W'(sc);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_beat.opcode;
            blk_reg <= BLOCK_BITS'(in_beat.block_number);
            bi_reg  <= in_beat.buffer_index;
        end
    end

    // one tag compare per cycle during the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
            hidx_reg  <= '0;
        end
        else if (cmd.scan_clr)
        begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (!found_reg && mapped_reg[sc] && tag_reg[sc] == blk_reg)
            begin
                found_reg <= 1'b1;
                hidx_reg  <= sc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg   <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            onlist_reg   <= '1;
            count_reg    <= CW'(NUM_BUFFERS);
            lp_reg       <= '0;
            removing_reg <= 1'b0;
            victim_reg   <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                order_reg[i] <= BW'(i);
                tag_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.lst_clr)
            begin
                lp_reg       <= '0;
                removing_reg <= 1'b0;
                victim_reg   <= order_reg[0];
            end
            else if (cmd.lst_step)
            begin
                // walk the list, shifting entries once the target is passed
                if (lp_reg < count_reg)
                begin
                    if (removing_reg || order_reg[lp_reg[BW-1:0]] == tgt)
                    begin
                        if (lp_reg + 1'b1 < count_reg)
                            order_reg[lp_reg[BW-1:0]] <= order_reg[BW'(lp_reg + 1'b1)];
                        else
                            count_reg <= count_reg - 1'b1;
                        removing_reg <= 1'b1;
                    end
                    lp_reg <= lp_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                unique case (op_reg)
                    OP_GET, OP_READ:
                    begin
                        onlist_reg[tgt] <= 1'b0;
                        if (!found_reg)
                        begin
                            dirty_reg[tgt]  <= 1'b0;
                            valid_reg[tgt]  <= (op_reg == OP_READ);
                            tag_reg[tgt]    <= blk_reg;
                            mapped_reg[tgt] <= 1'b1;
                        end
                        else if (op_reg == OP_READ && !dirty_reg[tgt])
                            valid_reg[tgt] <= 1'b1;
                    end
                    OP_WRITE:
                    begin
                        dirty_reg[tgt] <= 1'b0;
                        valid_reg[tgt] <= 1'b1;
                    end
                    OP_DWRITE:
                    begin
                        dirty_reg[tgt] <= 1'b1;
                        valid_reg[tgt] <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.append && !onlist_reg[tgt] && count_reg < CW'(NUM_BUFFERS))
            begin
                order_reg[count_reg[BW-1:0]] <= tgt;
                count_reg <= count_reg + 1'b1;
                onlist_reg[tgt] <= 1'b1;
            end
            if (cmd.flush_wb)
            begin
                dirty_reg[sc] <= 1'b0;
                valid_reg[sc] <= 1'b1;
            end
        end
    end
endmodule

### rtl/lbc_ctrl.sv
// sequencer of the buffer cache operations and output beat register
// depends on lbc_pkg
`timescale 1ns / 1ps
module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  lbc_in_t  in_beat,
    output logic     out_valid,
    input  logic     out_stall,
    output lbc_out_t out_beat,
    output lbc_cmd_t cmd,
    input  lbc_sts_t sts,
    input  logic     miss_empty,
    input  logic     victim_dirty,
    input  logic     need_read,
    input  logic     idx_ok,
    input  logic     any_dirty,
    input  logic [IDX_W-1:0] grant_idx,
    input  logic [BLK_W-1:0] victim_tag,
    input  logic [BLK_W-1:0] buf_tag,
    input  logic [BLK_W-1:0] scan_tag,
    input  logic [IDX_W-1:0] scan_idx
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WB    = 3'd2;
    localparam logic [2:0] S_GRANT = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg;
    logic       ov_reg;
    lbc_out_t   ob_reg;
    logic       emit;
    lbc_out_t   eb;
    logic       room;
    logic       is_get;

    assign room = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_beat = ob_reg;
    assign is_get = (op_reg == OP_GET || op_reg == OP_READ);

    always_comb
    begin
        state_next = state_reg;
        cmd  = '0;
        emit = 1'b0;
        eb   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    cmd.lst_clr = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_FLUSH)
                    state_next = S_FLUSH;
                else if (!is_get)
                    state_next = S_LIST;
                else if (!sts.scan_done)
                    cmd.scan_step = 1'b1;
                else if (miss_empty)
                begin
                    if (room)
                    begin
                        emit = 1'b1;
                        eb.status = 1'b1;
                        eb.last = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                    state_next = (!sts.hit && victim_dirty) ? S_WB : S_GRANT;
            end
            S_WB:
            begin
                if (room)
                begin
                    emit = 1'b1;
                    eb.buffer_index_out = grant_idx;
                    eb.disk_op = DISK_WRITE;
                    eb.disk_block = victim_tag;
                    eb.disk_buffer = grant_idx;
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                if (room)
                begin
                    emit = 1'b1;
                    eb.buffer_index_out = grant_idx;
                    eb.hit = sts.hit;
                    if (op_reg == OP_READ && need_read)
                    begin
                        eb.disk_op = DISK_READ;
                        eb.disk_block = buf_tag;
                        eb.disk_buffer = grant_idx;
                    end
                    eb.last = 1'b1;
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                if (is_get)
                begin
                    // grant emitted; unlink target then apply tag update
                    if (!sts.lst_done)
                        cmd.lst_step = 1'b1;
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (room)
                begin
                    emit = 1'b1;
                    eb.last = 1'b1;
                    if (idx_ok && op_reg == OP_WRITE)
                    begin
                        eb.disk_op = DISK_WRITE;
                        eb.disk_block = victim_tag;
                        eb.disk_buffer = grant_idx;
                    end
                    if (idx_ok && (op_reg == OP_RELEASE || op_reg == OP_WRITE
                                   || op_reg == OP_DWRITE))
                    begin
                        cmd.commit = 1'b1;
                        cmd.append = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                // nothing dirty can only be seen on entry
                if (!any_dirty)
                begin
                    if (room)
                    begin
                        emit = 1'b1;
                        eb.last = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.scan_dirty)
                begin
                    if (room)
                    begin
                        emit = 1'b1;
                        eb.disk_op = DISK_WRITE;
                        eb.disk_block = scan_tag;
                        eb.disk_buffer = scan_idx;
                        cmd.flush_wb = 1'b1;
                        cmd.scan_step = 1'b1;
                        // the written one is the last dirty buffer
                        if (sts.scan_last)
                        begin
                            eb.last = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            op_reg    <= OP_GET;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load)
                op_reg <= in_beat.opcode;
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            ob_reg <= eb;
    end
endmodule

### rtl/lru_block_buffer_cache.sv
// buffer cache top level: controller plus datapath
// depends on lbc_pkg, lbc_ctrl, lbc_datapath
`timescale 1ns / 1ps
// Fully associative cache manager for NUM_BUFFERS disk-block buffers with an
// LRU free list and delayed write. One request beat is taken at a time; the
// tag search walks one buffer per cycle and the free-list unlink one position
// per cycle. A get or read that misses writes back a dirty victim first, a
// miss with no free buffer ends after the search, and a flush registers a
// write-back beat in the cycle its dirty buffer is scanned, unless the output
// register is full and stalled, which holds back any ready result.
// Result beats leave through an output register that holds under stall.
module lru_block_buffer_cache
    import lbc_pkg::*;
#(
    parameter int NUM_BUFFERS = 16,
    parameter int BLOCK_BITS  = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  lbc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output lbc_out_t out_data
);
    lbc_cmd_t cmd;
    lbc_sts_t sts;
    logic miss_empty, victim_dirty, need_read, idx_ok, any_dirty;
    logic [IDX_W-1:0] grant_idx, scan_idx;
    logic [BLK_W-1:0] victim_tag, buf_tag, scan_tag;

    lbc_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .in_beat(in_data),
        .out_valid, .out_stall, .out_beat(out_data),
        .cmd, .sts, .miss_empty, .victim_dirty, .need_read, .idx_ok,
        .any_dirty, .grant_idx, .victim_tag, .buf_tag, .scan_tag, .scan_idx
    );

    lbc_datapath #(.NUM_BUFFERS(NUM_BUFFERS), .BLOCK_BITS(BLOCK_BITS)) u_dp (
        .clk, .rst_n, .in_beat(in_data), .cmd, .sts, .miss_empty,
        .victim_dirty, .need_read, .idx_ok, .any_dirty_reg_o(any_dirty),
        .grant_idx, .victim_tag, .buf_tag, .scan_tag, .scan_idx
    );
endmodule

### rtl/lbc_checker.sv
// port-level checks of the buffer cache
// depends on lbc_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "lru_block_buffer_cache_defines.svh"
module lbc_checker
    import lbc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input lbc_out_t out_data
);
    `LBC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(out_data))
    `LBC_ASSERT_IMPL(a_nocmd, clk, rst_n, out_valid && out_data.status, out_data.disk_op == DISK_NONE)
    `LBC_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind lru_block_buffer_cache lbc_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
